// ----- rtl/core/vdpp_pkg.sv -----
// Shared types, codes and constants of the video processor port interface.
`timescale 1ns / 1ps

package vdpp_pkg;

    localparam int VRAM_DEPTH = 16384;
    localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
    localparam int PTR_W      = 14;

    localparam logic [2:0] OP_CTRL_WR   = 3'd0;
    localparam logic [2:0] OP_DATA_WR   = 3'd1;
    localparam logic [2:0] OP_DATA_RD   = 3'd2;
    localparam logic [2:0] OP_STATUS_RD = 3'd3;
    localparam logic [2:0] OP_LINE_RD   = 3'd4;
    localparam logic [2:0] OP_LINE_TICK = 3'd5;

    localparam logic [1:0] AC_VRAM_RD = 2'd0;
    localparam logic [1:0] AC_VRAM_WR = 2'd1;
    localparam logic [1:0] AC_REG_WR  = 2'd2;
    localparam logic [1:0] AC_PAL_WR  = 2'd3;

    localparam logic [3:0] REG_IDX_MODE0  = 4'd0;
    localparam logic [3:0] REG_IDX_MODE1  = 4'd1;
    localparam logic [3:0] REG_IDX_RELOAD = 4'd10;

    localparam logic [7:0] MODE0_RST     = 8'h36;
    localparam logic [7:0] MODE1_RST     = 8'hA0;
    localparam logic [7:0] RELOAD_RST    = 8'hFF;
    localparam logic [7:0] COUNTDOWN_RST = 8'hFF;
    localparam logic [8:0] LPF_RST       = 9'd262;
    localparam logic [8:0] ACTIVE_SHORT  = 9'd192;
    localparam logic [8:0] ACTIVE_TALL   = 9'd224;
    localparam logic [8:0] LINE_CLAMP    = 9'd255;

    typedef logic [VRAM_AW-1:0] t_vaddr;
    typedef logic [PTR_W-1:0]   t_vptr;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_value;
        logic       irq;
    } t_out_word;

    typedef struct packed {
        logic [7:0] reg0;
        logic [7:0] reg1;
        logic [7:0] reg10;
    } t_mode_regs;

    typedef struct packed {
        logic vblank;
        logic line_zero;
    } t_line_evt;

endpackage

// ----- rtl/core/vdpp_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module vdpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/vdpp_timing.sv -----
// Scanline counter, line interrupt countdown and active-line selection.
`timescale 1ns / 1ps

module vdpp_timing import vdpp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  t_mode_regs i_mode,
    input  logic [8:0] i_lines_per_frame,
    output t_line_evt  o_evt,
    output logic [8:0] o_line_number
);

    logic [8:0] r_line_number, n_line_number;
    logic [7:0] r_countdown, n_countdown;
    logic       r_tall, n_tall;

    logic [8:0] active_cur;
    logic [8:0] active_new;
    logic [8:0] line_inc;
    logic [7:0] cd_eff;
    logic       in_blank;
    logic       first_line;
    logic       tall_sel;
    logic       tall_eff;

    always_comb begin
        active_cur = r_tall ? ACTIVE_TALL : ACTIVE_SHORT;
        in_blank   = (r_line_number >= active_cur);
        first_line = (r_line_number == 9'd0);
        tall_sel   = i_mode.reg0[2] && i_mode.reg0[1] && i_mode.reg1[4] && !i_mode.reg1[3];
        tall_eff   = first_line ? tall_sel : r_tall;
        active_new = tall_eff ? ACTIVE_TALL : ACTIVE_SHORT;
        cd_eff     = first_line ? i_mode.reg10 : r_countdown;
        line_inc   = r_line_number + 9'd1;

        o_evt.vblank    = !in_blank && (line_inc == active_new);
        o_evt.line_zero = !in_blank && (cd_eff == 8'd0);

        n_line_number = r_line_number;
        n_countdown   = r_countdown;
        n_tall        = r_tall;
        if (i_tick) begin
            if (in_blank) begin
                n_line_number = (line_inc == i_lines_per_frame) ? 9'd0 : line_inc;
            end else begin
                n_tall        = tall_eff;
                n_countdown   = (cd_eff == 8'd0) ? i_mode.reg10 : cd_eff - 8'd1;
                n_line_number = line_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_number <= '0;
            r_countdown   <= COUNTDOWN_RST;
            r_tall        <= 1'b0;
        end else begin
            r_line_number <= n_line_number;
            r_countdown   <= n_countdown;
            r_tall        <= n_tall;
        end
    end

    assign o_line_number = r_line_number;

endmodule

// ----- rtl/core/video_processor_port_interface_unit.sv -----
// Top level of the video processor port interface.
`timescale 1ns / 1ps

// Processor port of a tile video chip: control, data, status and line-number
// accesses plus scanline ticks, one input word each, one output word each.
// Input channel: i_in_valid / o_in_stall / i_in_word (op, data).
// Output channel: o_out_valid / i_out_stall / o_out_word (read_value, irq).
// Configuration: APB write of lines_per_frame at byte address 0.
// The output word is registered and valid in the cycle after its input word is taken.
// Throughput: one word per cycle outside the clearing pass; the input side keeps
// flowing while an output word is valid only if the output register frees up the same cycle.
// A data read returns the read-ahead byte; the video RAM fetch that refills
// it is issued in the same cycle and its registered read data serves as the
// read-ahead byte from the next cycle on.
// Reset: all control state returns to its reset value, then a clearing pass
// writes zero to every video RAM entry (VRAM_DEPTH, 16384), during
// which o_in_stall stays high. Configuration writes are taken throughout.
// Receiver stall: the output word holds; a new input word is taken only
// when the output register is empty or is being emptied.
// Palette writes advance nothing visible at the ports and are discarded.
module video_processor_port_interface_unit import vdpp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        r_clr_busy;
    t_vaddr      r_clr_addr;
    logic [8:0]  r_lpf;
    logic        r_second, n_second;
    logic [7:0]  r_ctrl_low, n_ctrl_low;
    logic [1:0]  r_access, n_access;
    t_vptr       r_vram_ptr, n_vram_ptr;
    logic [7:0]  r_read_ahead, n_read_ahead;
    logic        r_ra_ram, n_ra_ram;
    t_mode_regs  r_mode, n_mode;
    logic        r_vblank_flag, n_vblank_flag;
    logic        r_vblank_irq, n_vblank_irq;
    logic        r_line_irq, n_line_irq;
    logic        r_out_valid;
    t_out_word   r_out;

    logic        in_acc;
    logic        cfg_wr;
    logic        ram_we;
    logic        ram_re;
    t_vaddr      ram_addr;
    logic [7:0]  ram_wdata;
    logic [7:0]  ram_rdata;
    logic [7:0]  ra_cur;
    logic [7:0]  rv;
    t_vptr       ctrl_addr;
    logic        tick;
    t_line_evt   evt;
    logic [8:0]  line_number;

    assign o_in_stall = r_clr_busy || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign ra_cur     = r_ra_ram ? ram_rdata : r_read_ahead;
    assign ctrl_addr  = {i_in_word.data[5:0], r_ctrl_low};

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {23'd0, r_lpf};

    vdpp_ram #(
        .WIDTH(8),
        .DEPTH(VRAM_DEPTH)
    ) u_vram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    vdpp_timing u_timing (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tick           (tick),
        .i_mode           (r_mode),
        .i_lines_per_frame(r_lpf),
        .o_evt            (evt),
        .o_line_number    (line_number)
    );

    always_comb begin
        n_second      = r_second;
        n_ctrl_low    = r_ctrl_low;
        n_access      = r_access;
        n_vram_ptr    = r_vram_ptr;
        n_read_ahead  = r_read_ahead;
        n_ra_ram      = r_ra_ram;
        n_mode        = r_mode;
        n_vblank_flag = r_vblank_flag;
        n_vblank_irq  = r_vblank_irq;
        n_line_irq    = r_line_irq;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_addr      = t_vaddr'(r_vram_ptr);
        ram_wdata     = '0;
        tick          = 1'b0;
        rv            = '0;

        if (r_clr_busy) begin
            ram_we   = 1'b1;
            ram_addr = r_clr_addr;
        end else if (in_acc) begin
            case (i_in_word.op)
                OP_CTRL_WR: begin
                    if (!r_second) begin
                        n_ctrl_low = i_in_word.data;
                        n_second   = 1'b1;
                    end else begin
                        n_second = 1'b0;
                        n_access = i_in_word.data[7:6];
                        case (i_in_word.data[7:6])
                            AC_REG_WR: begin
                                case (i_in_word.data[3:0])
                                    REG_IDX_MODE0: begin
                                        n_mode.reg0 = r_ctrl_low;
                                        if (!r_ctrl_low[4]) begin
                                            n_line_irq = 1'b0;
                                        end
                                    end
                                    REG_IDX_MODE1: begin
                                        n_mode.reg1  = r_ctrl_low;
                                        n_vblank_irq = r_ctrl_low[5] && r_vblank_flag;
                                    end
                                    REG_IDX_RELOAD: begin
                                        n_mode.reg10 = r_ctrl_low;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                            AC_VRAM_RD: begin
                                ram_re     = 1'b1;
                                ram_addr   = t_vaddr'(ctrl_addr);
                                n_vram_ptr = ctrl_addr + t_vptr'(1);
                                n_ra_ram   = 1'b1;
                            end
                            AC_VRAM_WR: begin
                                n_vram_ptr = ctrl_addr;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                OP_DATA_WR: begin
                    n_second = 1'b0;
                    if (r_access != AC_PAL_WR) begin
                        ram_we       = 1'b1;
                        ram_wdata    = i_in_word.data;
                        n_read_ahead = i_in_word.data;
                        n_ra_ram     = 1'b0;
                        n_vram_ptr   = r_vram_ptr + t_vptr'(1);
                    end
                end
                OP_DATA_RD: begin
                    n_second   = 1'b0;
                    rv         = ra_cur;
                    ram_re     = 1'b1;
                    n_vram_ptr = r_vram_ptr + t_vptr'(1);
                    n_ra_ram   = 1'b1;
                end
                OP_STATUS_RD: begin
                    rv            = {r_vblank_flag, 7'd0};
                    n_vblank_flag = 1'b0;
                    n_second      = 1'b0;
                    n_vblank_irq  = 1'b0;
                    n_line_irq    = 1'b0;
                end
                OP_LINE_RD: begin
                    rv = (line_number >= LINE_CLAMP) ? 8'hFF : line_number[7:0];
                end
                OP_LINE_TICK: begin
                    tick = 1'b1;
                    if (evt.vblank) begin
                        n_vblank_flag = 1'b1;
                        if (r_mode.reg1[5]) begin
                            n_vblank_irq = 1'b1;
                        end
                    end
                    if (evt.line_zero && r_mode.reg0[4]) begin
                        n_line_irq = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy    <= 1'b1;
            r_clr_addr    <= '0;
            r_lpf         <= LPF_RST;
            r_second      <= 1'b0;
            r_ctrl_low    <= '0;
            r_access      <= AC_VRAM_RD;
            r_vram_ptr    <= '0;
            r_read_ahead  <= '0;
            r_ra_ram      <= 1'b0;
            r_mode        <= '{reg0: MODE0_RST, reg1: MODE1_RST, reg10: RELOAD_RST};
            r_vblank_flag <= 1'b0;
            r_vblank_irq  <= 1'b0;
            r_line_irq    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + t_vaddr'(1);
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (cfg_wr) begin
                r_lpf <= pwdata[8:0];
            end
            r_second      <= n_second;
            r_ctrl_low    <= n_ctrl_low;
            r_access      <= n_access;
            r_vram_ptr    <= n_vram_ptr;
            r_read_ahead  <= n_read_ahead;
            r_ra_ram      <= n_ra_ram;
            r_mode        <= n_mode;
            r_vblank_flag <= n_vblank_flag;
            r_vblank_irq  <= n_vblank_irq;
            r_line_irq    <= n_line_irq;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.read_value <= rv;
            r_out.irq        <= n_vblank_irq || n_line_irq;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_clear_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_out_valid)
        else $error("output word valid during the video RAM clearing pass");

    a_stalled_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !in_acc)
        else $error("input word taken while the output word is stalled");

    a_read_returns_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.op == OP_DATA_RD)
        |=> (o_out_word.read_value == $past(ra_cur)))
        else $error("data read did not return the read-ahead byte");

    a_status_clears_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.op == OP_STATUS_RD) |=> (!o_out_word.irq && o_out_valid))
        else $error("interrupt still pending after a status read");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the video processor port interface: random port traffic vs predictor.
`timescale 1ns / 1ps

module testbench;
    import vdpp_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int NUM_MODE_REGS   = 11;
    localparam int PAL_DEPTH       = 32;

    localparam logic [2:0] OP_UNUSED6 = 3'd6;
    localparam logic [2:0] OP_UNUSED7 = 3'd7;
    localparam logic [2:0] LPF_ADDR   = 3'd0;

    localparam logic [7:0] MODE_REGS_RST [NUM_MODE_REGS] = '{
        MODE0_RST, MODE1_RST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'h00, 8'h00, 8'h00, RELOAD_RST
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_word   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    video_processor_port_interface_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // predictor state
    logic [8:0]  lpf_cfg;
    logic        latch_hi;
    logic [7:0]  latch_lo;
    logic [1:0]  acc_code;
    logic [13:0] vptr;
    logic [7:0]  prefetch;
    logic [4:0]  pptr;
    logic [7:0]  regs_m [NUM_MODE_REGS];
    logic [7:0]  vram_m [VRAM_DEPTH];
    logic [7:0]  pal_m  [PAL_DEPTH];
    logic        vbl_flag;
    logic        vbl_irq;
    logic        ln_irq;
    logic [8:0]  line_no;
    logic [7:0]  countdown;
    logic [8:0]  active_n;

    t_in_word  port_words [$];
    t_out_word expected_words [$];
    t_out_word exp_word;

    int  errors       = 0;
    int  words_in     = 0;
    int  words_out    = 0;
    int  queued_total = 0;
    int  n_vblank     = 0;
    int  n_line_irq   = 0;
    int  cycle_count  = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    bit  in_took      = 1'b0;
    bit  squeeze      = 1'b0;
    bit  calm         = 1'b0;

    function automatic logic [7:0] fetch_vram();
        logic [7:0] b;
        b = vram_m[vptr];
        vptr = vptr + 1'b1;
        return b;
    endfunction

    task automatic vdp_port_access(input t_in_word w);
        t_out_word  r;
        logic [3:0] idx;
        r = '0;
        idx = w.data[3:0];
        case (w.op)
            OP_CTRL_WR: begin
                if (!latch_hi) begin
                    latch_lo = w.data;
                    latch_hi = 1'b1;
                end else begin
                    latch_hi = 1'b0;
                    acc_code = w.data[7:6];
                    case (acc_code)
                        AC_REG_WR: begin
                            if (idx < NUM_MODE_REGS) begin
                                regs_m[idx] = latch_lo;
                                if (idx == REG_IDX_MODE0 && !latch_lo[4])
                                    ln_irq = 1'b0;
                                if (idx == REG_IDX_MODE1)
                                    vbl_irq = latch_lo[5] & vbl_flag;
                            end
                        end
                        AC_PAL_WR: pptr = latch_lo[4:0];
                        AC_VRAM_RD: begin
                            vptr = {w.data[5:0], latch_lo};
                            prefetch = fetch_vram();
                        end
                        default: vptr = {w.data[5:0], latch_lo};
                    endcase
                end
            end
            OP_DATA_WR: begin
                latch_hi = 1'b0;
                if (acc_code == AC_PAL_WR) begin
                    pal_m[pptr] = w.data;
                    pptr = pptr + 1'b1;
                end else begin
                    prefetch = w.data;
                    vram_m[vptr] = w.data;
                    vptr = vptr + 1'b1;
                end
            end
            OP_DATA_RD: begin
                latch_hi = 1'b0;
                r.read_value = prefetch;
                prefetch = fetch_vram();
            end
            OP_STATUS_RD: begin
                r.read_value = {vbl_flag, 7'd0};
                vbl_flag = 1'b0;
                latch_hi = 1'b0;
                vbl_irq = 1'b0;
                ln_irq = 1'b0;
            end
            OP_LINE_RD: begin
                r.read_value = (line_no >= LINE_CLAMP) ? 8'hFF : line_no[7:0];
            end
            OP_LINE_TICK: begin
                if (line_no >= active_n) begin
                    line_no = line_no + 1'b1;
                    if (line_no == lpf_cfg)
                        line_no = '0;
                end else begin
                    if (line_no == 9'd0) begin
                        countdown = regs_m[REG_IDX_RELOAD];
                        if (regs_m[REG_IDX_MODE0][2] && regs_m[REG_IDX_MODE0][1] &&
                            regs_m[REG_IDX_MODE1][4] && !regs_m[REG_IDX_MODE1][3])
                            active_n = ACTIVE_TALL;
                        else
                            active_n = ACTIVE_SHORT;
                    end
                    if (countdown == 8'd0) begin
                        countdown = regs_m[REG_IDX_RELOAD];
                        if (regs_m[REG_IDX_MODE0][4]) begin
                            ln_irq = 1'b1;
                            n_line_irq++;
                        end
                    end else begin
                        countdown = countdown - 1'b1;
                    end
                    line_no = line_no + 1'b1;
                    if (line_no == active_n) begin
                        vbl_flag = 1'b1;
                        n_vblank++;
                        if (regs_m[REG_IDX_MODE1][5])
                            vbl_irq = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.irq = vbl_irq | ln_irq;
        expected_words.push_back(r);
    endtask

    // input side: hold the word until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else if (port_words.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_in_valid <= 1'b0;
                gap_left = $urandom_range(0, 13);
            end else begin
                i_in_valid <= 1'b1;
                i_in_word  <= port_words.pop_front();
            end
        end
    end

    // output side stall bursts
    always @(negedge i_clk) begin
        if (squeeze) begin
            i_out_stall <= 1'b1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 13);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_out++;
            if (expected_words.size() == 0) begin
                $display("%0t: output word %h with nothing expected", $time, o_out_word);
                errors++;
            end else begin
                exp_word = expected_words.pop_front();
                if (o_out_word.read_value !== exp_word.read_value) begin
                    $display("%0t: read_value expected %02h actual %02h",
                             $time, exp_word.read_value, o_out_word.read_value);
                    errors++;
                end
                if (o_out_word.irq !== exp_word.irq) begin
                    $display("%0t: irq expected %b actual %b",
                             $time, exp_word.irq, o_out_word.irq);
                    errors++;
                end
            end
        end
        in_took = i_rst_n && i_in_valid && !o_in_stall;
        if (in_took) begin
            words_in++;
            vdp_port_access(i_in_word);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached, %0d results outstanding",
                     $time, expected_words.size());
            $display("tb: failure");
            $finish;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        do @(negedge i_clk); while (words_in < 150);
        squeeze <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
        squeeze <= 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic logic [13:0] pick_addr();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 3))
            0, 1: r[13:6] = '0;
            2: r[13:6] = '1;
            default: ;
        endcase
        return r[13:0];
    endfunction

    task automatic put(input logic [2:0] op, input logic [7:0] data);
        t_in_word w;
        w.op = op;
        w.data = data;
        port_words.push_back(w);
        queued_total++;
    endtask

    task automatic queue_sequence();
        int          kind;
        int          n;
        int          k;
        logic [13:0] a;
        logic [7:0]  v;
        logic [7:0]  hi;
        logic [3:0]  idx;
        kind = $urandom_range(0, 99);
        n = $urandom_range(1, 8);
        a = pick_addr();
        if (kind < 20) begin
            put(OP_CTRL_WR, a[7:0]);
            put(OP_CTRL_WR, {AC_VRAM_WR, a[13:8]});
            repeat (n) put(OP_DATA_WR, rand_byte());
        end else if (kind < 35) begin
            put(OP_CTRL_WR, a[7:0]);
            put(OP_CTRL_WR, {AC_VRAM_RD, a[13:8]});
            repeat (n) put(OP_DATA_RD, rand_byte());
        end else if (kind < 45) begin
            v = rand_byte();
            hi = rand_byte();
            case ($urandom_range(0, 4))
                0: idx = REG_IDX_MODE0;
                1: idx = REG_IDX_MODE1;
                2: begin
                    idx = REG_IDX_RELOAD;
                    if ($urandom_range(0, 2) != 0)
                        v[7:3] = '0;
                end
                3: idx = hi[3:0];
                default: begin
                    k = $urandom_range(NUM_MODE_REGS, 15);
                    idx = k[3:0];
                end
            endcase
            put(OP_CTRL_WR, v);
            put(OP_CTRL_WR, {AC_REG_WR, hi[5:4], idx});
        end else if (kind < 50) begin
            v = rand_byte();
            put(OP_CTRL_WR, rand_byte());
            put(OP_CTRL_WR, {AC_PAL_WR, v[5:0]});
            repeat (n) put(OP_DATA_WR, rand_byte());
            if ($urandom_range(0, 1) == 0)
                put(OP_DATA_RD, rand_byte());
        end else if (kind < 80) begin
            repeat (n + $urandom_range(0, 4)) put(OP_LINE_TICK, rand_byte());
            put(OP_LINE_RD, rand_byte());
        end else if (kind < 88) begin
            put(($urandom_range(0, 1) == 0) ? OP_STATUS_RD : OP_LINE_RD, rand_byte());
        end else if (kind < 95) begin
            // drop the second control byte
            put(OP_CTRL_WR, rand_byte());
            case ($urandom_range(0, 3))
                0: put(OP_DATA_WR, rand_byte());
                1: put(OP_DATA_RD, rand_byte());
                2: put(OP_STATUS_RD, rand_byte());
                default: put(OP_LINE_TICK, rand_byte());
            endcase
        end else begin
            repeat ($urandom_range(1, 3)) begin
                v = rand_byte();
                put(v[2:0], rand_byte());
            end
        end
    endtask

    task automatic queue_random(input int count);
        int goal;
        @(posedge i_clk);
        goal = queued_total + count;
        while (queued_total < goal) queue_sequence();
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (port_words.size() != 0 || i_in_valid);
        do @(negedge i_clk); while (expected_words.size() != 0);
    endtask

    task automatic set_frame_lines(input logic [8:0] lines);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LPF_ADDR;
        pwdata  <= {23'd0, lines};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[8:0] !== lines) begin
            $display("%0t: lines_per_frame readback expected %0d actual %0d",
                     $time, lines, prdata[8:0]);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        lpf_cfg = lines;
    endtask

    initial begin
        lpf_cfg   = LPF_RST;
        latch_hi  = 1'b0;
        latch_lo  = '0;
        acc_code  = AC_VRAM_RD;
        vptr      = '0;
        prefetch  = '0;
        pptr      = '0;
        vbl_flag  = 1'b0;
        vbl_irq   = 1'b0;
        ln_irq    = 1'b0;
        line_no   = '0;
        countdown = COUNTDOWN_RST;
        active_n  = ACTIVE_SHORT;
        for (int i = 0; i < NUM_MODE_REGS; i++) regs_m[i] = MODE_REGS_RST[i];
        for (int i = 0; i < VRAM_DEPTH; i++) vram_m[i] = '0;
        for (int i = 0; i < PAL_DEPTH; i++) pal_m[i] = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_frame_lines(9'd313);

        @(posedge i_clk);
        put(OP_STATUS_RD, 8'h00);
        put(OP_LINE_RD, 8'hFF);
        put(OP_CTRL_WR, 8'hFF);
        put(OP_CTRL_WR, {AC_VRAM_WR, 6'h3F});
        put(OP_DATA_WR, 8'hA5);
        put(OP_DATA_WR, 8'h5A);
        put(OP_CTRL_WR, 8'hFF);
        put(OP_CTRL_WR, {AC_VRAM_RD, 6'h3F});
        put(OP_DATA_RD, 8'h00);
        put(OP_DATA_RD, 8'hFF);
        put(OP_CTRL_WR, 8'h1F);
        put(OP_CTRL_WR, {AC_PAL_WR, 6'h3F});
        put(OP_DATA_WR, 8'hFF);
        put(OP_DATA_WR, 8'h00);
        put(OP_CTRL_WR, 8'h77);
        put(OP_CTRL_WR, {AC_REG_WR, 2'b11, 4'hF});
        put(OP_CTRL_WR, 8'h02);
        put(OP_CTRL_WR, {AC_REG_WR, 2'b00, REG_IDX_RELOAD});
        put(OP_CTRL_WR, 8'h30);
        put(OP_CTRL_WR, {AC_REG_WR, 2'b00, REG_IDX_MODE1});
        put(OP_CTRL_WR, 8'h55);
        put(OP_DATA_RD, 8'h00);
        repeat (3) put(OP_LINE_TICK, 8'h00);
        put(OP_UNUSED6, 8'hFF);
        put(OP_UNUSED7, 8'h00);
        wait_drained();

        queue_random(250);
        wait_drained();

        // park the line counter deep in blanking, then shorten the frame under it
        while (line_no < 9'd240) begin
            @(posedge i_clk);
            put(OP_LINE_TICK, rand_byte());
            wait_drained();
        end
        set_frame_lines(9'd225);
        @(posedge i_clk);
        repeat (300) begin
            put(OP_LINE_TICK, rand_byte());
            if ($urandom_range(0, 3) == 0)
                put(OP_LINE_RD, rand_byte());
        end
        wait_drained();
        queue_random(150);
        wait_drained();

        set_frame_lines(9'($urandom_range(226, 312)));
        queue_random(150);
        wait_drained();

        set_frame_lines(LPF_RST);
        calm <= 1'b1;
        queue_random(150);
        wait_drained();

        repeat (12) @(negedge i_clk);
        $display("covered %0d port words, %0d results, %0d vblank entries, %0d line interrupts",
                 words_in, words_out, n_vblank, n_line_irq);
        $display("frame lengths 313, 225, random and 262, including a line counter wrap");
        if (errors == 0 && expected_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
